// File: sv/rapq_pkg.sv
// rapq_pkg: shared widths, defaults and item mode codes
// for the range-add point-query tree block
// no dependencies
package rapq_pkg;

    // default number of leaves the store is built for
    localparam int LEAVES_DEF = 1024;

    // item field widths
    localparam int MODE_W = 2;
    localparam int IDX_W  = 11;
    localparam int VAL_W  = 32;
    localparam int SUM_W  = 64;

    // item mode codes
    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

endpackage

// File: sv/rapq_ram.sv
// rapq_ram: generic single-port ram with registered read data
// read-first on a write; no dependencies
module rapq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one access per cycle, old data returned on a write
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/range_add_point_query_tree.sv
// Range-add point-query segment tree over up to LEAVES leaves.
// Input channel s_*: one item per handshake. s_mode selects load leaf,
// range add or point query; s_first_index / s_last_index are 1-based,
// s_value is a signed 32-bit leaf value or addend. Only a point query
// produces a result on m_point_value; an out-of-range query answers 0.
// Config channel cfg_*: writes size_in_use, the number of leaves in use
// (0 acts as 1, above LEAVES acts as LEAVES). Always ready.
// The tree lives in one 64-bit single-port ram of 2*LEAVES nodes with
// registered read data. Items run one at a time: a load walks down to
// its leaf, then writes it; a query reads and accumulates each node on
// the path to its leaf, then hands the sum on; an add visits the nodes
// of its span and writes back each node wholly inside it plus the addend.
// s_ready is high only while the sequencer is idle. After reset a clearing
// pass zeroes all 2*LEAVES nodes, one per cycle (2048 for the default),
// with s_ready low; config writes are still taken. A finished query waits
// until the output register is free, so a stalled receiver holds the
// block; otherwise the next item is taken while a result waits.
module range_add_point_query_tree
    import rapq_pkg::*;
#(
    parameter int LEAVES = LEAVES_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // item input
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [MODE_W-1:0]       s_mode,
    input  logic [IDX_W-1:0]        s_first_index,
    input  logic [IDX_W-1:0]        s_last_index,
    input  logic signed [VAL_W-1:0] s_value,
    // result output
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [SUM_W-1:0] m_point_value,
    // size register write
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [IDX_W-1:0]        cfg_size_in_use
);

    localparam int STORE_DEPTH = 2 * LEAVES;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int NODE_W      = $clog2(LEAVES) + 2;
    localparam int LV_W        = $clog2(LEAVES + 1);
    localparam int CMP_W       = (LV_W > IDX_W) ? LV_W : IDX_W;
    localparam int STK_DEPTH   = $clog2(LEAVES) + 1;
    localparam int STK_W       = $clog2(STK_DEPTH + 1);
    localparam int SP_W        = $clog2(STK_DEPTH);

    localparam logic [CMP_W-1:0]  LEAVES_C = CMP_W'(LEAVES);
    localparam logic [CMP_W-1:0]  ONE_C    = CMP_W'(1);
    localparam logic [NODE_W-1:0] ROOT_C   = NODE_W'(1);
    localparam logic [NODE_W-1:0] DEPTH_C  = NODE_W'(STORE_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_C   = ADDR_W'(STORE_DEPTH - 1);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD_WALK,
        ST_ADD_EVAL,
        ST_ADD_WR,
        ST_Q_RD,
        ST_Q_ACC,
        ST_Q_DONE
    } state_t;

    state_t                    state_reg, state_next;
    logic [ADDR_W-1:0]         clr_cnt_reg, clr_cnt_next;
    logic [CMP_W-1:0]          size_reg, size_next;
    logic [NODE_W-1:0]         node_reg, node_next;
    logic [CMP_W-1:0]          lo_reg, lo_next;
    logic [CMP_W-1:0]          hi_reg, hi_next;
    logic [CMP_W-1:0]          a_reg, a_next;
    logic [CMP_W-1:0]          b_reg, b_next;
    logic [SUM_W-1:0]          val_reg, val_next;
    logic [SUM_W-1:0]          sum_reg, sum_next;
    logic                      hit_reg, hit_next;
    logic [STK_W-1:0]          sp_reg, sp_next;
    logic                      m_valid_reg, m_valid_next;
    logic [SUM_W-1:0]          m_value_reg, m_value_next;

    // pending right children of the add walk
    logic [NODE_W-1:0]         stk_node_reg [STK_DEPTH];
    logic [CMP_W-1:0]          stk_lo_reg   [STK_DEPTH];
    logic [CMP_W-1:0]          stk_hi_reg   [STK_DEPTH];

    logic                      push_en;
    logic [SP_W-1:0]           push_idx, pop_idx;

    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_addr;
    logic [SUM_W-1:0]          mem_wdata, mem_rdata;

    logic [CMP_W-1:0]          n_eff, s_a, s_b, mid;
    logic [CMP_W:0]            lo_hi_sum;
    logic                      in_store, disjoint, covered, go_left;
    logic [NODE_W-1:0]         left_node, right_node;

    rapq_ram #(
        .WIDTH (SUM_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // effective size and node geometry
    always_comb begin
        if (size_reg == '0) begin
            n_eff = ONE_C;
        end else if (size_reg > LEAVES_C) begin
            n_eff = LEAVES_C;
        end else begin
            n_eff = size_reg;
        end
        s_a        = CMP_W'(s_first_index);
        s_b        = CMP_W'(s_last_index);
        lo_hi_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
        mid        = lo_hi_sum[CMP_W:1];
        go_left    = (a_reg <= mid);
        left_node  = {node_reg[NODE_W-2:0], 1'b0};
        right_node = {node_reg[NODE_W-2:0], 1'b1};
        in_store   = (node_reg < DEPTH_C);
        disjoint   = (b_reg < lo_reg) || (hi_reg < a_reg);
        covered    = (a_reg <= lo_reg) && (hi_reg <= b_reg);
        push_idx   = sp_reg[SP_W-1:0];
        pop_idx    = SP_W'(sp_reg - STK_W'(1));
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        size_next    = size_reg;
        node_next    = node_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        val_next     = val_reg;
        sum_next     = sum_reg;
        hit_next     = hit_reg;
        sp_next      = sp_reg;
        m_valid_next = m_valid_reg;
        m_value_next = m_value_reg;
        push_en      = 1'b0;
        mem_we       = 1'b0;
        mem_addr     = node_reg[ADDR_W-1:0];
        mem_wdata    = mem_rdata + val_reg;

        // output register drains
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // size register write
        if (cfg_valid) begin
            size_next = CMP_W'(cfg_size_in_use);
        end

        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = clr_cnt_reg;
                mem_wdata = '0;
                if (clr_cnt_reg == LAST_C) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                end
            end

            ST_IDLE: begin
                if (s_valid) begin
                    node_next = ROOT_C;
                    lo_next   = ONE_C;
                    hi_next   = n_eff;
                    a_next    = s_a;
                    b_next    = s_b;
                    val_next  = SUM_W'(s_value);
                    sum_next  = '0;
                    sp_next   = '0;
                    case (s_mode)
                        MODE_LOAD: begin
                            if (s_a inside {[ONE_C:n_eff]}) begin
                                state_next = ST_LOAD_WALK;
                            end
                        end
                        MODE_ADD: begin
                            if (s_a <= s_b) begin
                                state_next = ST_ADD_EVAL;
                            end
                        end
                        MODE_QUERY: begin
                            if (s_a inside {[ONE_C:n_eff]}) begin
                                state_next = ST_Q_RD;
                            end else begin
                                state_next = ST_Q_DONE;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // walk down to the leaf, then write it
            ST_LOAD_WALK: begin
                if (lo_reg < hi_reg) begin
                    if (go_left) begin
                        node_next = left_node;
                        hi_next   = mid;
                    end else begin
                        node_next = right_node;
                        lo_next   = mid + ONE_C;
                    end
                end else begin
                    mem_we     = in_store;
                    mem_wdata  = val_reg;
                    state_next = ST_IDLE;
                end
            end

            // visit one node of the add walk
            ST_ADD_EVAL: begin
                if (covered && in_store && !disjoint) begin
                    // read issued now, data back in ST_ADD_WR
                    state_next = ST_ADD_WR;
                end else if (disjoint || covered) begin
                    if (sp_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        sp_next   = sp_reg - STK_W'(1);
                        node_next = stk_node_reg[pop_idx];
                        lo_next   = stk_lo_reg[pop_idx];
                        hi_next   = stk_hi_reg[pop_idx];
                    end
                end else begin
                    push_en   = 1'b1;
                    sp_next   = sp_reg + STK_W'(1);
                    node_next = left_node;
                    hi_next   = mid;
                end
            end

            // write back node plus addend, then resume the walk
            ST_ADD_WR: begin
                mem_we = 1'b1;
                if (sp_reg == '0) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_ADD_EVAL;
                    sp_next    = sp_reg - STK_W'(1);
                    node_next  = stk_node_reg[pop_idx];
                    lo_next    = stk_lo_reg[pop_idx];
                    hi_next    = stk_hi_reg[pop_idx];
                end
            end

            // path sum: read node, then accumulate and step down
            ST_Q_RD: begin
                hit_next   = in_store;
                state_next = ST_Q_ACC;
            end

            ST_Q_ACC: begin
                sum_next = sum_reg + (hit_reg ? mem_rdata : '0);
                if (lo_reg < hi_reg) begin
                    state_next = ST_Q_RD;
                    if (go_left) begin
                        node_next = left_node;
                        hi_next   = mid;
                    end else begin
                        node_next = right_node;
                        lo_next   = mid + ONE_C;
                    end
                end else begin
                    state_next = ST_Q_DONE;
                end
            end

            // hand the sum to the output register once it is free
            ST_Q_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_value_next = sum_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            size_reg    <= LEAVES_C;
            sp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            size_reg    <= size_next;
            sp_reg      <= sp_next;
            m_valid_reg <= m_valid_next;
        end
        node_reg    <= node_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        val_reg     <= val_next;
        sum_reg     <= sum_next;
        hit_reg     <= hit_next;
        m_value_reg <= m_value_next;
        if (push_en) begin
            stk_node_reg[push_idx] <= right_node;
            stk_lo_reg[push_idx]   <= mid + ONE_C;
            stk_hi_reg[push_idx]   <= hi_reg;
        end
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_valid       = m_valid_reg;
    assign m_point_value = m_value_reg;

endmodule

// File: sv/rapq_checker.sv
// rapq_checker: port-level checks for the range-add point-query tree
// depends on rapq_pkg; bound to range_add_point_query_tree below
module rapq_checker
    import rapq_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic [MODE_W-1:0]       s_mode,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic signed [SUM_W-1:0] m_point_value
);

    // a waiting result holds until taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_point_value))
        else $error("result changed while stalled");

    // reset empties the output and blocks items as the clearing pass begins
    assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("not quiet after reset");

    // load, add and unused items never produce a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_mode != MODE_QUERY && !m_valid |=> !m_valid)
        else $error("result from a non-query item");

    // an accepted query takes the sequencer out of idle in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_mode == MODE_QUERY |=> !s_ready)
        else $error("ready right after a query");

endmodule

bind range_add_point_query_tree rapq_checker u_rapq_checker (.*);

// File: tb/sv/tb_range_add_point_query_tree.sv
`timescale 1ns / 1ps
// tb_range_add_point_query_tree: self-checking bench for the range-add point-query tree,
// with its own tree model, directed corner items and random item traffic per size setting
// depends on rapq_pkg and range_add_point_query_tree
module tb_range_add_point_query_tree;
    import rapq_pkg::*;

    localparam int NODES         = 2 * LEAVES_DEF;
    localparam int IDX_MAX       = (1 << IDX_W) - 1;
    localparam int SETTLE_CYCLES = 200;
    localparam int PHASE_ITEMS   = 105;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic [IDX_W-1:0]        first_index;
        logic [IDX_W-1:0]        last_index;
        logic signed [VAL_W-1:0] value;
    } tree_item_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [MODE_W-1:0]       s_mode = MODE_LOAD;
    logic [IDX_W-1:0]        s_first_index = '0;
    logic [IDX_W-1:0]        s_last_index = '0;
    logic signed [VAL_W-1:0] s_value = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic signed [SUM_W-1:0] m_point_value;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [IDX_W-1:0]        cfg_size_in_use = '0;

    // bench state
    tree_item_t       pending_items[$];
    logic [SUM_W-1:0] expected_sums[$];
    logic [SUM_W-1:0] node_sums[NODES];
    logic [IDX_W-1:0] size_reg = IDX_W'(LEAVES_DEF);
    int unsigned      mismatch_count = 0;
    int unsigned      item_gap = 0;
    int unsigned      stall_left = 0;
    bit               idling_on = 1'b1;
    bit               stalls_on = 1'b1;

    range_add_point_query_tree #(
        .LEAVES(LEAVES_DEF)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_first_index  (s_first_index),
        .s_last_index   (s_last_index),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_point_value  (m_point_value),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_size_in_use(cfg_size_in_use)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------------------------------------------------------- tree model

    // size 0 behaves as 1, anything above the build size as the build size
    function automatic int unsigned eff_leaves(logic [IDX_W-1:0] sz);
        if (sz == 0) return 1;
        if (sz > LEAVES_DEF) return LEAVES_DEF;
        return 32'(sz);
    endfunction

    // nodes past the store read as zero and are never written
    function automatic logic [SUM_W-1:0] node_get(int unsigned k);
        return (k < NODES) ? node_sums[k] : '0;
    endfunction

    function automatic void node_put(int unsigned k, logic [SUM_W-1:0] v);
        if (k < NODES) node_sums[k] = v;
    endfunction

    function automatic int unsigned leaf_of(int unsigned idx, int unsigned n);
        int unsigned k, lo, hi, mid;
        k = 1;
        lo = 1;
        hi = n;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (idx <= mid) begin
                k = 2 * k;
                hi = mid;
            end else begin
                k = 2 * k + 1;
                lo = mid + 1;
            end
        end
        return k;
    endfunction

    // walk root to leaf, summing every node on the way
    function automatic logic [SUM_W-1:0] path_sum(int unsigned idx, int unsigned n);
        int unsigned k, lo, hi, mid;
        logic [SUM_W-1:0] sum;
        k = 1;
        lo = 1;
        hi = n;
        sum = '0;
        forever begin
            sum = sum + node_get(k);
            if (lo >= hi) break;
            mid = (lo + hi) / 2;
            if (idx <= mid) begin
                k = 2 * k;
                hi = mid;
            end else begin
                k = 2 * k + 1;
                lo = mid + 1;
            end
        end
        return sum;
    endfunction

    // add to every maximal node lying wholly inside [a,b]
    function automatic void add_span(input int unsigned k, input int unsigned lo,
                                     input int unsigned hi, input int unsigned a,
                                     input int unsigned b, input logic [SUM_W-1:0] addend);
        int unsigned mid;
        if (b < lo || hi < a) return;
        if (a <= lo && hi <= b) begin
            node_put(k, node_get(k) + addend);
            return;
        end
        mid = (lo + hi) / 2;
        add_span(2 * k, lo, mid, a, b, addend);
        add_span(2 * k + 1, mid + 1, hi, a, b, addend);
    endfunction

    // update the model for one accepted item, queue the sum a query should return
    function automatic void apply_item(tree_item_t it);
        int unsigned n, a, b;
        logic [SUM_W-1:0] wide;
        n = eff_leaves(size_reg);
        a = 32'(it.first_index);
        b = 32'(it.last_index);
        wide = {{(SUM_W-VAL_W){it.value[VAL_W-1]}}, it.value};
        case (it.mode)
            MODE_LOAD: begin
                if (a >= 1 && a <= n) node_put(leaf_of(a, n), wide);
            end
            MODE_ADD: begin
                if (a <= b) add_span(1, 1, n, a, b, wide);
            end
            MODE_QUERY: begin
                expected_sums = {expected_sums,
                                 ((a >= 1 && a <= n) ? path_sum(a, n) : '0)};
            end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    // mostly no gap, some short, a few long
    function automatic int unsigned pick_gap(bit enabled);
        int unsigned roll;
        roll = $urandom_range(99);
        if (!enabled || roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    function automatic logic [IDX_W-1:0] pick_index(int unsigned n);
        if ($urandom_range(9) == 0) return IDX_W'($urandom_range(IDX_MAX));
        return IDX_W'($urandom_range(1, n));
    endfunction

    function automatic tree_item_t random_item(int unsigned n);
        tree_item_t it;
        int unsigned roll;
        logic [IDX_W-1:0] swap;
        roll = $urandom_range(99);
        it.value = $urandom();
        if ($urandom_range(3) == 0) it.value = $urandom_range(40) - 20;
        it.first_index = pick_index(n);
        it.last_index = IDX_W'($urandom_range(IDX_MAX));
        if (roll < 20) begin
            it.mode = MODE_LOAD;
        end else if (roll < 50) begin
            // mostly ordered spans, now and then an empty one
            it.mode = MODE_ADD;
            it.last_index = pick_index(n);
            if (it.first_index > it.last_index && $urandom_range(9) != 0) begin
                swap = it.first_index;
                it.first_index = it.last_index;
                it.last_index = swap;
            end
        end else if (roll < 96) begin
            it.mode = MODE_QUERY;
        end else begin
            it.mode = MODE_UNUSED;
        end
        return it;
    endfunction

    function automatic void queue_item(logic [MODE_W-1:0] mode, int unsigned a,
                                       int unsigned b, logic [VAL_W-1:0] v);
        tree_item_t it;
        it.mode = mode;
        it.first_index = IDX_W'(a);
        it.last_index = IDX_W'(b);
        it.value = v;
        pending_items = {pending_items, it};
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic write_size(input logic [IDX_W-1:0] sz);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_size_in_use <= sz;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // all items sent, all sums back, then room for a trailing add to finish
    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_items.size() != 0 || s_valid || expected_sums.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // ---------------------------------------------------------------- driver and monitor

    // item driver with random gaps after each accepted item
    always @(posedge aclk) begin : drive_items
        tree_item_t next_item;
        if (!aresetn) begin
            s_valid <= 1'b0;
            item_gap <= 0;
        end else if (!s_valid || s_ready) begin
            if (item_gap != 0) begin
                s_valid <= 1'b0;
                item_gap <= item_gap - 1;
            end else if (pending_items.size() != 0) begin
                next_item = pending_items.pop_front();
                s_valid <= 1'b1;
                s_mode <= next_item.mode;
                s_first_index <= next_item.first_index;
                s_last_index <= next_item.last_index;
                s_value <= next_item.value;
                item_gap <= pick_gap(idling_on);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(posedge aclk) begin : drive_ready
        int unsigned stall;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            stall = pick_gap(stalls_on);
            m_ready <= (stall == 0);
            stall_left <= (stall == 0) ? 0 : stall - 1;
        end
    end

    // track size writes and items, check each returned sum
    always @(posedge aclk) begin : track_tree
        tree_item_t seen;
        logic [SUM_W-1:0] want;
        if (!aresetn) begin
            foreach (node_sums[k]) node_sums[k] = '0;
            size_reg = IDX_W'(LEAVES_DEF);
            expected_sums.delete();
        end else begin
            if (cfg_valid && cfg_ready) size_reg = cfg_size_in_use;
            if (m_valid && m_ready) begin
                if (expected_sums.size() == 0) begin
                    report_mismatch($sformatf("unexpected point_value %0d", m_point_value));
                end else begin
                    want = expected_sums.pop_front();
                    if (m_point_value !== want)
                        report_mismatch($sformatf("point_value %0d, want %0d",
                                                  m_point_value, $signed(want)));
                end
            end
            if (s_valid && s_ready) begin
                seen.mode = s_mode;
                seen.first_index = s_first_index;
                seen.last_index = s_last_index;
                seen.value = s_value;
                apply_item(seen);
            end
        end
    end

    // ---------------------------------------------------------------- test sequence

    initial begin : run_test
        int unsigned sizes[8];
        int unsigned n;
        sizes = '{0, IDX_MAX, 1, 2, 5, LEAVES_DEF, 0, 1000};
        sizes[6] = $urandom_range(3, LEAVES_DEF - 1);
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed corners at the reset size
        queue_item(MODE_LOAD, 1, 0, 32'h7fff_ffff);
        queue_item(MODE_LOAD, LEAVES_DEF, IDX_MAX, 32'h8000_0000);
        queue_item(MODE_LOAD, 0, 0, 32'd5);
        queue_item(MODE_LOAD, LEAVES_DEF + 1, 0, 32'd7);
        queue_item(MODE_LOAD, IDX_MAX, 0, 32'hffff_ffff);
        queue_item(MODE_QUERY, 1, 0, 32'd0);
        queue_item(MODE_QUERY, LEAVES_DEF, 0, 32'd0);
        queue_item(MODE_QUERY, 0, IDX_MAX, 32'hffff_ffff);
        queue_item(MODE_QUERY, IDX_MAX, 0, 32'd0);
        queue_item(MODE_ADD, 1, LEAVES_DEF, 32'hffff_ffff);
        queue_item(MODE_ADD, 5, 3, 32'd100);
        queue_item(MODE_ADD, 0, IDX_MAX, 32'h8000_0000);
        queue_item(MODE_ADD, LEAVES_DEF + 1, IDX_MAX, 32'd9);
        queue_item(MODE_ADD, 512, 513, 32'h1234_5678);
        queue_item(MODE_UNUSED, 1, LEAVES_DEF, 32'd77);
        queue_item(MODE_QUERY, 512, 0, 32'd0);
        queue_item(MODE_QUERY, 513, 0, 32'd0);
        queue_item(MODE_QUERY, 1, 0, 32'd0);
        queue_item(MODE_QUERY, 700, 0, 32'd0);
        queue_item(MODE_ADD, LEAVES_DEF, LEAVES_DEF, 32'h7fff_ffff);
        queue_item(MODE_QUERY, LEAVES_DEF, 0, 32'd0);
        wait_drained();

        // random traffic under each size setting, contents carried across
        foreach (sizes[p]) begin
            idling_on = (p != 3 && p != 5);
            stalls_on = (p != 3 && p != 6);
            write_size(IDX_W'(sizes[p]));
            n = eff_leaves(IDX_W'(sizes[p]));
            repeat (PHASE_ITEMS) pending_items = {pending_items, random_item(n)};
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // hang guard
    initial begin : watchdog
        #(20_000_000);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
